[design/dpdd_pkg.sv]
// Package for the dual PID differential drive block.
// Register indexes, reset values, clamp limits and the pipeline control struct.
// No dependencies.
package dpdd_pkg;

	localparam int ANGLE_WIDTH_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CORR_W      = 10;
	localparam int COMPARE_W   = 16;
	localparam int SUM_W       = 32;

	localparam int CORR_MAX = 300;
	localparam int CORR_MIN = -300;

	localparam logic [CFG_INDEX_W-1:0] REG_KP_LEFT    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KI_LEFT    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_LEFT    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KP_RIGHT   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_KI_RIGHT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_RIGHT   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEFT  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_RIGHT = 3'd7;

	localparam logic [CFG_DATA_W-1:0] KP_RESET   = 16'd1280;
	localparam logic [CFG_DATA_W-1:0] KI_RESET   = 16'd0;
	localparam logic [CFG_DATA_W-1:0] KD_RESET   = 16'd0;
	localparam logic [CFG_DATA_W-1:0] BASE_RESET = 16'd700;

	typedef struct packed {
		logic accept;
		logic advance;
	} pipe_ctl_t;

endpackage

[design/dpdd_in_if.sv]
// Input channel: one word carries a left and a right angle sample.
// Valid/ready handshake; no package dependency.
interface dpdd_in_if #(
	parameter int ANGLE_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] angle_left;
	logic signed [ANGLE_WIDTH-1:0] angle_right;

	modport source (output valid, output angle_left, output angle_right, input ready);
	modport sink   (input valid, input angle_left, input angle_right, output ready);
endinterface

[design/dpdd_out_if.sv]
// Output channel: four PWM compare values and the two clamped corrections.
// Valid/ready handshake; no package dependency.
interface dpdd_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       compare_one;
	logic [15:0]       compare_two;
	logic [15:0]       compare_three;
	logic [15:0]       compare_four;
	logic signed [9:0] correction_left;
	logic signed [9:0] correction_right;

	modport source (output valid, output compare_one, output compare_two,
		output compare_three, output compare_four, output correction_left,
		output correction_right, input ready);
	modport sink   (input valid, input compare_one, input compare_two,
		input compare_three, input compare_four, input correction_left,
		input correction_right, output ready);
endinterface

[design/dpdd_pid.sv]
// One positional PID loop: error, saturating integrator, three products, clamp.
// Three stages (_s1 error, _s2 products, _s3 correction). Uses dpdd_pkg.
module dpdd_pid #(
	parameter int ANGLE_WIDTH    = dpdd_pkg::ANGLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = dpdd_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dpdd_pkg::pipe_ctl_t               ctl,
	input  logic signed [ANGLE_WIDTH-1:0]     angle,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]   kp,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]   ki,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]   kd,
	output logic signed [dpdd_pkg::CORR_W-1:0] corr
);
	localparam int SUM_W  = dpdd_pkg::SUM_W;
	localparam int G_W    = dpdd_pkg::CFG_DATA_W + 1;
	localparam int E_W    = ANGLE_WIDTH + 1;
	localparam int D_W    = ANGLE_WIDTH + 2;
	localparam int SX_W   = ((E_W > SUM_W) ? E_W : SUM_W) + 1;
	localparam int PP_W   = E_W + G_W;
	localparam int PI_W   = SUM_W + G_W;
	localparam int PD_W   = D_W + G_W;
	localparam int ACC_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
	localparam int OVF_W  = SX_W - SUM_W + 1;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [E_W-1:0]   prev_q;

	logic signed [E_W-1:0]   err;
	logic signed [SX_W-1:0]  sum_x;
	logic signed [SUM_W-1:0] sum_nxt;
	logic signed [D_W-1:0]   delta;
	logic [OVF_W-1:0]        sum_top;

	logic signed [E_W-1:0]   e_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [D_W-1:0]   d_s1;

	logic signed [PP_W-1:0]  pp_s2;
	logic signed [PI_W-1:0]  pi_s2;
	logic signed [PD_W-1:0]  pd_s2;

	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [dpdd_pkg::CORR_W-1:0] corr_s3;

	assign err     = -$signed({angle[ANGLE_WIDTH-1], angle});
	assign sum_x   = SX_W'(sum_q) + SX_W'(err);
	assign sum_top = sum_x[SX_W-1:SUM_W-1];
	assign delta   = D_W'(err) - D_W'(prev_q);

	always_comb begin
		if (!sum_x[SX_W-1] && (|sum_top)) begin
			sum_nxt = {1'b0, {(SUM_W-1){1'b1}}};
		end else if (sum_x[SX_W-1] && !(&sum_top)) begin
			sum_nxt = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_nxt = sum_x[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctl.accept) begin
			sum_q  <= sum_nxt;
			prev_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			e_s1   <= err;
			sum_s1 <= sum_nxt;
			d_s1   <= delta;
		end
		if (ctl.advance) begin
			pp_s2 <= PP_W'($signed({1'b0, kp})) * PP_W'(e_s1);
			pi_s2 <= PI_W'($signed({1'b0, ki})) * PI_W'(sum_s1);
			pd_s2 <= PD_W'($signed({1'b0, kd})) * PD_W'(d_s1);
		end
	end

	// arithmetic shift rounds toward minus infinity
	assign acc    = ACC_W'(pp_s2) + ACC_W'(pi_s2) + ACC_W'(pd_s2);
	assign acc_sh = acc >>> GAIN_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			priority if (acc_sh > ACC_W'(dpdd_pkg::CORR_MAX)) begin
				corr_s3 <= dpdd_pkg::CORR_W'(dpdd_pkg::CORR_MAX);
			end else if (acc_sh < ACC_W'(dpdd_pkg::CORR_MIN)) begin
				corr_s3 <= dpdd_pkg::CORR_W'(dpdd_pkg::CORR_MIN);
			end else begin
				corr_s3 <= acc_sh[dpdd_pkg::CORR_W-1:0];
			end
		end
	end

	assign corr = corr_s3;

endmodule

[design/dual_pid_differential_drive.sv]
// Dual PID differential drive: two PID loops and four saturated PWM compare values.
// An accepted sample word passes the error, products, correction and output register
// stages in that order to the result word; one word per cycle sustained while the output
// is not stalled. A stalled output holds the whole chain. Async
// active-low reset clears the integrators, previous errors, valid bits and loads the
// gain and base defaults. Depends on dpdd_pkg, dpdd_in_if, dpdd_out_if and dpdd_pid.
module dual_pid_differential_drive #(
	parameter int ANGLE_WIDTH    = dpdd_pkg::ANGLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = dpdd_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dpdd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]    cfg_data,
	dpdd_in_if.sink                            samples,
	dpdd_out_if.source                         results
);
	localparam int CW  = dpdd_pkg::CFG_DATA_W;
	localparam int OW  = dpdd_pkg::COMPARE_W;
	localparam int BW  = OW + 2;

	logic [CW-1:0] kp_left_q, ki_left_q, kd_left_q;
	logic [CW-1:0] kp_right_q, ki_right_q, kd_right_q;
	logic [CW-1:0] base_left_q, base_right_q;

	logic v_s1, v_s2, v_s3, res_valid_q;
	dpdd_pkg::pipe_ctl_t ctl;

	logic signed [ANGLE_WIDTH-1:0] angle_l, angle_r;
	logic signed [dpdd_pkg::CORR_W-1:0] corr_l, corr_r;

	logic [OW-1:0] cmp1_q, cmp2_q, cmp3_q, cmp4_q;
	logic signed [dpdd_pkg::CORR_W-1:0] corr_l_q, corr_r_q;

	function automatic logic [OW-1:0] sat_u16(input logic signed [BW-1:0] v);
		if (v < 0) begin
			sat_u16 = '0;
		end else if (v > $signed({2'b00, {OW{1'b1}}})) begin
			sat_u16 = '1;
		end else begin
			sat_u16 = v[OW-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_left_q    <= dpdd_pkg::KP_RESET;
			ki_left_q    <= dpdd_pkg::KI_RESET;
			kd_left_q    <= dpdd_pkg::KD_RESET;
			kp_right_q   <= dpdd_pkg::KP_RESET;
			ki_right_q   <= dpdd_pkg::KI_RESET;
			kd_right_q   <= dpdd_pkg::KD_RESET;
			base_left_q  <= dpdd_pkg::BASE_RESET;
			base_right_q <= dpdd_pkg::BASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpdd_pkg::REG_KP_LEFT:    kp_left_q    <= cfg_data;
				dpdd_pkg::REG_KI_LEFT:    ki_left_q    <= cfg_data;
				dpdd_pkg::REG_KD_LEFT:    kd_left_q    <= cfg_data;
				dpdd_pkg::REG_KP_RIGHT:   kp_right_q   <= cfg_data;
				dpdd_pkg::REG_KI_RIGHT:   ki_right_q   <= cfg_data;
				dpdd_pkg::REG_KD_RIGHT:   kd_right_q   <= cfg_data;
				dpdd_pkg::REG_BASE_LEFT:  base_left_q  <= cfg_data;
				dpdd_pkg::REG_BASE_RIGHT: base_right_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ctl.advance   = !res_valid_q || results.ready;
	assign ctl.accept    = samples.valid && ctl.advance;
	assign samples.ready = ctl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (ctl.advance) begin
			v_s1        <= ctl.accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	assign angle_l = samples.angle_left;
	assign angle_r = samples.angle_right;

	dpdd_pid #(
		.ANGLE_WIDTH    (ANGLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_pid_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.angle  (angle_l),
		.kp     (kp_left_q),
		.ki     (ki_left_q),
		.kd     (kd_left_q),
		.corr   (corr_l)
	);

	dpdd_pid #(
		.ANGLE_WIDTH    (ANGLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_pid_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.angle  (angle_r),
		.kp     (kp_right_q),
		.ki     (ki_right_q),
		.kd     (kd_right_q),
		.corr   (corr_r)
	);

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			cmp1_q   <= sat_u16($signed({2'b00, base_left_q})  + BW'(corr_l));
			cmp2_q   <= sat_u16($signed({2'b00, base_right_q}) + BW'(corr_r));
			cmp3_q   <= sat_u16($signed({2'b00, base_left_q})  - BW'(corr_l));
			cmp4_q   <= sat_u16($signed({2'b00, base_right_q}) - BW'(corr_r));
			corr_l_q <= corr_l;
			corr_r_q <= corr_r;
		end
	end

	assign results.valid            = res_valid_q;
	assign results.compare_one      = cmp1_q;
	assign results.compare_two      = cmp2_q;
	assign results.compare_three    = cmp3_q;
	assign results.compare_four     = cmp4_q;
	assign results.correction_left  = corr_l_q;
	assign results.correction_right = corr_r_q;

	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.correction_left <= 10'sd300 &&
			results.correction_left >= -10'sd300 &&
			results.correction_right <= 10'sd300 &&
			results.correction_right >= -10'sd300))
		else $error("correction out of clamp range");

	a_left_order: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.correction_left >= 0) |->
			(results.compare_one >= results.compare_three))
		else $error("left compare values out of order");

	a_right_order: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.correction_right >= 0) |->
			(results.compare_two >= results.compare_four))
		else $error("right compare values out of order");

	a_pipe_move: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept) |=> v_s1)
		else $error("accepted word lost in first stage");

endmodule
